[rtl/sorted_timer_queue_assert.svh]
// Assertion macros shared by the timer queue RTL.
`ifndef SORTED_TIMER_QUEUE_ASSERT_SVH
`define SORTED_TIMER_QUEUE_ASSERT_SVH

// The condition holds at every clock edge outside reset.
`define STQ_ASSERT_ALWAYS(lbl, cond, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) \
        else $error(msg);

// Whenever the antecedent holds, the consequent holds in the same cycle.
`define STQ_ASSERT_IMPLY(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

[rtl/stq_pkg.sv]
package stq_pkg;

    localparam int DEPTH_DEFAULT = 16;

    typedef enum logic [1:0] {
        REQ_TICK   = 2'd0,
        REQ_ADD    = 2'd1,
        REQ_REMOVE = 2'd2,
        REQ_QUERY  = 2'd3
    } t_req_type;

    typedef enum logic [2:0] {
        KIND_EXPIRED    = 3'd0,
        KIND_ADDED      = 3'd1,
        KIND_TABLE_FULL = 3'd2,
        KIND_ZERO_DELAY = 3'd3,
        KIND_REMOVED    = 3'd4,
        KIND_NOT_FOUND  = 3'd5,
        KIND_QUERY      = 3'd6,
        KIND_TICK_DONE  = 3'd7
    } t_kind;

    typedef struct packed {
        t_req_type   req_type;
        logic [15:0] delay_seconds;
        logic [15:0] cookie;
        logic [3:0]  handle;
    } t_req;

    typedef struct packed {
        t_kind              event_kind;
        logic [3:0]         slot;
        logic [15:0]        tag;
        logic signed [31:0] time_value;
        logic               queue_empty;
        logic               last;
    } t_rsp;

    typedef struct packed {
        logic ord_we;
        logic slot_we;
    } t_mem_ctl;

endpackage

[rtl/stq_chan_if.sv]
interface stq_chan_if #(
    parameter type T = logic
) ();
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

[rtl/stq_store.sv]
module stq_store #(
    parameter int DEPTH = stq_pkg::DEPTH_DEFAULT,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic              i_clk,
    input  stq_pkg::t_mem_ctl i_ctl,
    input  logic [AW-1:0]     i_ord_raddr,
    input  logic [AW-1:0]     i_ord_waddr,
    input  logic [AW-1:0]     i_ord_wdata,
    output logic [AW-1:0]     o_ord_rdata,
    input  logic [AW-1:0]     i_slot_raddr,
    input  logic [AW-1:0]     i_slot_waddr,
    input  logic [31:0]       i_slot_wdl,
    input  logic [15:0]       i_slot_wtag,
    output logic [31:0]       o_slot_rdl,
    output logic [15:0]       o_slot_rtag
);

    logic [AW-1:0] r_ord_mem [DEPTH];
    logic [31:0]   r_dl_mem  [DEPTH];
    logic [15:0]   r_tag_mem [DEPTH];
    logic [AW-1:0] r_ord_rdata;
    logic [31:0]   r_dl_rdata;
    logic [15:0]   r_tag_rdata;

    always_ff @(posedge i_clk) begin
        if (i_ctl.ord_we) begin
            r_ord_mem[i_ord_waddr] <= i_ord_wdata;
        end
        r_ord_rdata <= r_ord_mem[i_ord_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.slot_we) begin
            r_dl_mem[i_slot_waddr]  <= i_slot_wdl;
            r_tag_mem[i_slot_waddr] <= i_slot_wtag;
        end
        r_dl_rdata  <= r_dl_mem[i_slot_raddr];
        r_tag_rdata <= r_tag_mem[i_slot_raddr];
    end

    assign o_ord_rdata = r_ord_rdata;
    assign o_slot_rdl  = r_dl_rdata;
    assign o_slot_rtag = r_tag_rdata;

endmodule

[rtl/sorted_timer_queue.sv]
// Channel  Dir  Modport  Transfer carries
// i_req    in   sink     req_type, delay_seconds, cookie, handle
// o_rsp    out  source   event_kind, slot, tag, time_value, queue_empty, last
//
// One request at a time; a new transfer on i_req is taken only in the idle state, after
// the previous request has placed its final result in the output register.
// A tick or a refused add walks its E expiries; an accepted add walks its E expiries,
// then scans the A timers sorted ahead of it and shifts the B behind; a remove scans the
// P timers ahead of the slot and shifts the S behind; not found and query walk no list.
// Reset is synchronous and active low and needs no clearing pass.
// A stalled o_rsp holds the sequencer at its next result.
module sorted_timer_queue #(
    parameter int DEPTH = stq_pkg::DEPTH_DEFAULT
) (
    input logic i_clk,
    input logic i_rst_n,
    stq_chan_if.sink   i_req,
    stq_chan_if.source o_rsp
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    typedef enum logic [22:0] {
        ST_IDLE     = 23'd1 << 0,
        ST_SC_ORD   = 23'd1 << 1,
        ST_SC_SLOT  = 23'd1 << 2,
        ST_SC_CHK   = 23'd1 << 3,
        ST_EM_ORD   = 23'd1 << 4,
        ST_EM_SLOT  = 23'd1 << 5,
        ST_EM_OUT   = 23'd1 << 6,
        ST_ADD      = 23'd1 << 7,
        ST_IN_ORD   = 23'd1 << 8,
        ST_IN_SLOT  = 23'd1 << 9,
        ST_IN_CHK   = 23'd1 << 10,
        ST_SH_RD    = 23'd1 << 11,
        ST_SH_WR    = 23'd1 << 12,
        ST_IN_PUT   = 23'd1 << 13,
        ST_RM_ORD   = 23'd1 << 14,
        ST_RM_CHK   = 23'd1 << 15,
        ST_RM_SH_RD = 23'd1 << 16,
        ST_RM_SH_WR = 23'd1 << 17,
        ST_QRY      = 23'd1 << 18,
        ST_EA_ORD   = 23'd1 << 19,
        ST_EA_SLOT  = 23'd1 << 20,
        ST_EA_CALC  = 23'd1 << 21,
        ST_FIN      = 23'd1 << 22
    } t_state;

    function automatic logic [AW-1:0] f_phys(input logic [AW-1:0] head,
                                             input logic [CW-1:0] off);
        logic [CW:0] sum;
        sum = (CW+1)'(head) + (CW+1)'(off);
        if (sum >= (CW+1)'(DEPTH)) begin
            sum = sum - (CW+1)'(DEPTH);
        end
        return AW'(sum);
    endfunction

    t_state              r_state, n_state;
    logic [31:0]         r_time, n_time;
    logic [CW-1:0]       r_count, n_count;
    logic [AW-1:0]       r_head, n_head;
    logic [DEPTH-1:0]    r_in_use, n_in_use;
    logic                r_out_valid, n_out_valid;
    stq_pkg::t_rsp       r_out, n_out;
    stq_pkg::t_req       r_req, n_req;
    logic [CW-1:0]       r_idx, n_idx;
    logic [CW-1:0]       r_nexp, n_nexp;
    logic [CW-1:0]       r_pos, n_pos;
    logic [AW-1:0]       r_slot, n_slot;
    logic [AW-1:0]       r_new, n_new;
    logic                r_empty, n_empty;
    stq_pkg::t_kind      r_fkind, n_fkind;
    logic [3:0]          r_fslot, n_fslot;
    logic [15:0]         r_ftag, n_ftag;
    logic [31:0]         r_ftv, n_ftv;

    stq_pkg::t_mem_ctl   mem_ctl;
    logic [AW-1:0]       ord_raddr, ord_waddr, ord_wdata, ord_rdata;
    logic [AW-1:0]       slot_raddr, slot_waddr;
    logic [31:0]         slot_wdl, slot_rdl;
    logic [15:0]         slot_rtag;
    logic [31:0]         diff;
    logic                out_free;
    logic                in_fire;
    logic [AW-1:0]       in_hidx, req_hidx, free_slot;
    logic                in_found;

    stq_store #(.DEPTH(DEPTH)) u_store (
        .i_clk        (i_clk),
        .i_ctl        (mem_ctl),
        .i_ord_raddr  (ord_raddr),
        .i_ord_waddr  (ord_waddr),
        .i_ord_wdata  (ord_wdata),
        .o_ord_rdata  (ord_rdata),
        .i_slot_raddr (slot_raddr),
        .i_slot_waddr (slot_waddr),
        .i_slot_wdl   (slot_wdl),
        .i_slot_wtag  (r_req.cookie),
        .o_slot_rdl   (slot_rdl),
        .o_slot_rtag  (slot_rtag)
    );

    assign i_req.ready = (r_state == ST_IDLE);
    assign in_fire     = i_req.valid && (r_state == ST_IDLE);
    assign out_free    = !r_out_valid || o_rsp.ready;
    assign o_rsp.valid = r_out_valid;
    assign o_rsp.data  = r_out;
    assign diff        = slot_rdl - r_time;
    assign in_hidx     = AW'(i_req.data.handle);
    assign req_hidx    = AW'(r_req.handle);
    assign in_found    = (int'(i_req.data.handle) < DEPTH) && r_in_use[in_hidx];

    always_comb begin
        free_slot = '0;
        for (int k = DEPTH - 1; k >= 0; k--) begin
            if (!r_in_use[k]) begin
                free_slot = AW'(k);
            end
        end
    end

    always_comb begin
        n_state     = r_state;
        n_time      = r_time;
        n_count     = r_count;
        n_head      = r_head;
        n_in_use    = r_in_use;
        n_out_valid = r_out_valid && !o_rsp.ready;
        n_out       = r_out;
        n_req       = r_req;
        n_idx       = r_idx;
        n_nexp      = r_nexp;
        n_pos       = r_pos;
        n_slot      = r_slot;
        n_new       = r_new;
        n_empty     = r_empty;
        n_fkind     = r_fkind;
        n_fslot     = r_fslot;
        n_ftag      = r_ftag;
        n_ftv       = r_ftv;
        mem_ctl     = '0;
        ord_raddr   = r_head;
        ord_waddr   = f_phys(r_head, r_idx);
        ord_wdata   = ord_rdata;
        slot_raddr  = req_hidx;
        slot_waddr  = free_slot;
        slot_wdl    = r_time + 32'(r_req.delay_seconds);

        case (r_state)
            ST_IDLE: begin
                slot_raddr = in_hidx;
                if (in_fire) begin
                    n_req   = i_req.data;
                    n_idx   = '0;
                    n_pos   = '0;
                    n_fslot = i_req.data.handle;
                    n_ftag  = '0;
                    case (i_req.data.req_type)
                        stq_pkg::REQ_TICK: begin
                            n_time  = r_time + 32'd1;
                            n_state = ST_SC_ORD;
                        end
                        stq_pkg::REQ_ADD: begin
                            n_state = ST_SC_ORD;
                        end
                        default: begin
                            if (!in_found) begin
                                n_fkind = stq_pkg::KIND_NOT_FOUND;
                                n_state = ST_EA_ORD;
                            end else if (i_req.data.req_type == stq_pkg::REQ_REMOVE) begin
                                n_fkind = stq_pkg::KIND_REMOVED;
                                n_state = ST_RM_ORD;
                            end else begin
                                n_fkind = stq_pkg::KIND_QUERY;
                                n_state = ST_QRY;
                            end
                        end
                    endcase
                end
            end
            ST_SC_ORD: begin
                ord_raddr = f_phys(r_head, r_idx);
                if (r_idx == r_count) begin
                    n_nexp  = r_idx;
                    n_empty = !((r_req.req_type == stq_pkg::REQ_ADD) &&
                                (r_req.delay_seconds != 16'd0));
                    n_state = ST_EM_ORD;
                end else begin
                    n_state = ST_SC_SLOT;
                end
            end
            ST_SC_SLOT: begin
                slot_raddr = ord_rdata;
                n_state    = ST_SC_CHK;
            end
            ST_SC_CHK: begin
                if (diff[31] || (diff == 32'd0)) begin
                    n_idx   = r_idx + CW'(1);
                    n_state = ST_SC_ORD;
                end else begin
                    n_nexp  = r_idx;
                    n_empty = 1'b0;
                    n_state = ST_EM_ORD;
                end
            end
            ST_EM_ORD: begin
                n_fslot = '0;
                n_ftag  = '0;
                if (r_nexp != '0) begin
                    n_state = ST_EM_SLOT;
                end else if (r_req.req_type == stq_pkg::REQ_TICK) begin
                    n_fkind = stq_pkg::KIND_TICK_DONE;
                    n_state = ST_EA_ORD;
                end else if (r_req.delay_seconds == 16'd0) begin
                    n_fkind = stq_pkg::KIND_ZERO_DELAY;
                    n_state = ST_EA_ORD;
                end else if (r_count == CW'(DEPTH)) begin
                    n_fkind = stq_pkg::KIND_TABLE_FULL;
                    n_state = ST_EA_ORD;
                end else begin
                    n_state = ST_ADD;
                end
            end
            ST_EM_SLOT: begin
                slot_raddr = ord_rdata;
                n_slot     = ord_rdata;
                n_state    = ST_EM_OUT;
            end
            ST_EM_OUT: begin
                slot_raddr = r_slot;
                if (out_free) begin
                    n_out_valid          = 1'b1;
                    n_out.event_kind     = stq_pkg::KIND_EXPIRED;
                    n_out.slot           = 4'(r_slot);
                    n_out.tag            = slot_rtag;
                    n_out.time_value     = '0;
                    n_out.queue_empty    = r_empty;
                    n_out.last           = 1'b0;
                    n_in_use[r_slot]     = 1'b0;
                    n_head               = f_phys(r_head, CW'(1));
                    n_count              = r_count - CW'(1);
                    n_nexp               = r_nexp - CW'(1);
                    n_state              = ST_EM_ORD;
                end
            end
            ST_ADD: begin
                mem_ctl.slot_we = 1'b1;
                n_new           = free_slot;
                n_pos           = '0;
                n_fkind         = stq_pkg::KIND_ADDED;
                n_fslot         = 4'(free_slot);
                n_ftag          = r_req.cookie;
                n_state         = ST_IN_ORD;
            end
            ST_IN_ORD: begin
                ord_raddr = f_phys(r_head, r_pos);
                if (r_pos == r_count) begin
                    n_idx   = r_count;
                    n_state = ST_SH_RD;
                end else begin
                    n_state = ST_IN_SLOT;
                end
            end
            ST_IN_SLOT: begin
                slot_raddr = ord_rdata;
                n_state    = ST_IN_CHK;
            end
            ST_IN_CHK: begin
                if ($signed(diff) <= $signed({16'd0, r_req.delay_seconds})) begin
                    n_pos   = r_pos + CW'(1);
                    n_state = ST_IN_ORD;
                end else begin
                    n_idx   = r_count;
                    n_state = ST_SH_RD;
                end
            end
            ST_SH_RD: begin
                ord_raddr = f_phys(r_head, r_idx - CW'(1));
                if (r_idx == r_pos) begin
                    n_state = ST_IN_PUT;
                end else begin
                    n_state = ST_SH_WR;
                end
            end
            ST_SH_WR: begin
                mem_ctl.ord_we = 1'b1;
                n_idx          = r_idx - CW'(1);
                n_state        = ST_SH_RD;
            end
            ST_IN_PUT: begin
                mem_ctl.ord_we   = 1'b1;
                ord_waddr        = f_phys(r_head, r_pos);
                ord_wdata        = r_new;
                n_count          = r_count + CW'(1);
                n_in_use[r_new]  = 1'b1;
                n_state          = ST_EA_ORD;
            end
            ST_RM_ORD: begin
                ord_raddr = f_phys(r_head, r_pos);
                n_state   = ST_RM_CHK;
            end
            ST_RM_CHK: begin
                if ((ord_rdata == req_hidx) || (r_pos + CW'(1) >= r_count)) begin
                    n_idx   = r_pos;
                    n_ftag  = slot_rtag;
                    n_state = ST_RM_SH_RD;
                end else begin
                    n_pos   = r_pos + CW'(1);
                    n_state = ST_RM_ORD;
                end
            end
            ST_RM_SH_RD: begin
                ord_raddr = f_phys(r_head, r_idx + CW'(1));
                if (r_idx + CW'(1) >= r_count) begin
                    n_count            = r_count - CW'(1);
                    n_in_use[req_hidx] = 1'b0;
                    n_state            = ST_EA_ORD;
                end else begin
                    n_state = ST_RM_SH_WR;
                end
            end
            ST_RM_SH_WR: begin
                mem_ctl.ord_we = 1'b1;
                n_idx          = r_idx + CW'(1);
                n_state        = ST_RM_SH_RD;
            end
            ST_QRY: begin
                n_ftv   = diff;
                n_state = ST_FIN;
            end
            ST_EA_ORD: begin
                if (r_count == '0) begin
                    n_ftv   = '0;
                    n_state = ST_FIN;
                end else begin
                    n_state = ST_EA_SLOT;
                end
            end
            ST_EA_SLOT: begin
                slot_raddr = ord_rdata;
                n_state    = ST_EA_CALC;
            end
            ST_EA_CALC: begin
                n_ftv   = diff;
                n_state = ST_FIN;
            end
            ST_FIN: begin
                if (out_free) begin
                    n_out_valid       = 1'b1;
                    n_out.event_kind  = r_fkind;
                    n_out.slot        = r_fslot;
                    n_out.tag         = r_ftag;
                    n_out.time_value  = r_ftv;
                    n_out.queue_empty = (r_count == '0);
                    n_out.last        = 1'b1;
                    n_state           = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_time      <= '0;
            r_count     <= '0;
            r_head      <= '0;
            r_in_use    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_time      <= n_time;
            r_count     <= n_count;
            r_head      <= n_head;
            r_in_use    <= n_in_use;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out   <= n_out;
        r_req   <= n_req;
        r_idx   <= n_idx;
        r_nexp  <= n_nexp;
        r_pos   <= n_pos;
        r_slot  <= n_slot;
        r_new   <= n_new;
        r_empty <= n_empty;
        r_fkind <= n_fkind;
        r_fslot <= n_fslot;
        r_ftag  <= n_ftag;
        r_ftv   <= n_ftv;
    end

`include "sorted_timer_queue_assert.svh"

    `STQ_ASSERT_ALWAYS(a_count_bound, r_count <= CW'(DEPTH), "pending count above depth")
    `STQ_ASSERT_ALWAYS(a_use_matches_count, $countones(r_in_use) == int'(r_count), "slot use and pending count disagree")
    `STQ_ASSERT_IMPLY(a_expiry_not_last, r_out_valid && (r_out.event_kind == stq_pkg::KIND_EXPIRED), !r_out.last, "expiry result marked last")

endmodule

[tb/tb_top.sv]
module tb_top;

    localparam int DEPTH = stq_pkg::DEPTH_DEFAULT;

    logic i_clk;
    logic i_rst_n;

    stq_chan_if #(.T(stq_pkg::t_req)) req_if ();
    stq_chan_if #(.T(stq_pkg::t_rsp)) rsp_if ();

    sorted_timer_queue #(.DEPTH(DEPTH)) i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if.sink),
        .o_rsp   (rsp_if.source)
    );

    logic [31:0] now_sec;
    logic [31:0] deadline_mem [DEPTH];
    logic [15:0] cookie_mem [DEPTH];
    logic        busy_slot [DEPTH];
    int          order_q [$];

    stq_pkg::t_req pending_reqs [$];
    stq_pkg::t_rsp expected_rsps [$];
    int   errors;
    bit   hold_req;
    int   hold_cnt;
    bit   req_taken;
    bit   rsp_taken;

    function automatic logic signed [31:0] offset_of(logic [31:0] dl);
        return $signed(dl - now_sec);
    endfunction

    function automatic logic [31:0] earliest_delay();
        if (order_q.size() == 0) return 32'd0;
        return deadline_mem[order_q[0]] - now_sec;
    endfunction

    function automatic stq_pkg::t_rsp mk(stq_pkg::t_kind k, logic [3:0] s, logic [15:0] t,
                                         logic [31:0] tv, logic lst);
        stq_pkg::t_rsp r;
        r.event_kind  = k;
        r.slot        = s;
        r.tag         = t;
        r.time_value  = tv;
        r.queue_empty = 1'b0;
        r.last        = lst;
        return r;
    endfunction

    task automatic predict_request(stq_pkg::t_req rq);
        stq_pkg::t_rsp outs [$];
        int   s;
        int   pos;
        logic signed [31:0] off;
        if (rq.req_type == stq_pkg::REQ_TICK || rq.req_type == stq_pkg::REQ_ADD) begin
            if (rq.req_type == stq_pkg::REQ_TICK) now_sec = now_sec + 1;
            while (order_q.size() > 0 && offset_of(deadline_mem[order_q[0]]) <= 0) begin
                s = order_q.pop_front();
                outs.push_back(mk(stq_pkg::KIND_EXPIRED, s[3:0], cookie_mem[s], 32'd0,
                                  1'b0));
                busy_slot[s] = 1'b0;
            end
        end
        case (rq.req_type)
            stq_pkg::REQ_TICK: begin
                outs.push_back(mk(stq_pkg::KIND_TICK_DONE, 4'd0, 16'd0, earliest_delay(),
                                  1'b1));
            end
            stq_pkg::REQ_ADD: begin
                if (rq.delay_seconds == 0) begin
                    outs.push_back(mk(stq_pkg::KIND_ZERO_DELAY, 4'd0, 16'd0,
                                      earliest_delay(), 1'b1));
                end else if (order_q.size() >= DEPTH) begin
                    outs.push_back(mk(stq_pkg::KIND_TABLE_FULL, 4'd0, 16'd0,
                                      earliest_delay(), 1'b1));
                end else begin
                    s = 0;
                    while (s < DEPTH && busy_slot[s]) s++;
                    busy_slot[s] = 1'b1;
                    deadline_mem[s] = now_sec + rq.delay_seconds;
                    cookie_mem[s] = rq.cookie;
                    off = offset_of(deadline_mem[s]);
                    pos = 0;
                    while (pos < order_q.size() && offset_of(deadline_mem[order_q[pos]]) <= off)
                        pos++;
                    order_q.insert(pos, s);
                    outs.push_back(mk(stq_pkg::KIND_ADDED, s[3:0], rq.cookie,
                                      earliest_delay(), 1'b1));
                end
            end
            default: begin
                s = rq.handle;
                if (!(s < DEPTH && busy_slot[s])) begin
                    outs.push_back(mk(stq_pkg::KIND_NOT_FOUND, rq.handle, 16'd0,
                                      earliest_delay(), 1'b1));
                end else if (rq.req_type == stq_pkg::REQ_REMOVE) begin
                    foreach (order_q[i]) if (order_q[i] == s) pos = i;
                    order_q.delete(pos);
                    busy_slot[s] = 1'b0;
                    outs.push_back(mk(stq_pkg::KIND_REMOVED, s[3:0], cookie_mem[s],
                                      earliest_delay(), 1'b1));
                end else begin
                    outs.push_back(mk(stq_pkg::KIND_QUERY, s[3:0], 16'd0,
                                      deadline_mem[s] - now_sec, 1'b1));
                end
            end
        endcase
        foreach (outs[i]) begin
            outs[i].queue_empty = (order_q.size() == 0);
            expected_rsps.push_back(outs[i]);
        end
    endtask

    function automatic stq_pkg::t_req mk_req(stq_pkg::t_req_type k, int d, int c, int h);
        stq_pkg::t_req r;
        r.req_type      = k;
        r.delay_seconds = d[15:0];
        r.cookie        = c[15:0];
        r.handle        = h[3:0];
        return r;
    endfunction

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    initial begin
        #60000000;
        $display("Simulation FAILED");
        $finish;
    end

    // Transfers seen at the rising edge, used by the falling-edge processes.
    always @(posedge i_clk) begin
        req_taken <= i_rst_n && req_if.valid && req_if.ready;
        rsp_taken <= i_rst_n && rsp_if.valid && rsp_if.ready;
    end

    // Driver: one transfer at a time, random gap before each item.
    int drv_gap;
    initial begin
        req_if.valid = 1'b0;
        req_if.data  = '0;
        drv_gap = 0;
    end
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (req_taken) begin
                req_if.valid <= 1'b0;
                drv_gap = $urandom_range(0, 6);
            end else if (!req_if.valid) begin
                if (drv_gap > 0) begin
                    drv_gap--;
                end else if (pending_reqs.size() > 0) begin
                    req_if.data  <= pending_reqs.pop_front();
                    req_if.valid <= 1'b1;
                end
            end
        end
    end

    // Receiver backpressure, with a long hold counted here on request.
    int rcv_gap;
    initial begin
        rsp_if.ready = 1'b0;
        rcv_gap = 0;
        hold_cnt = 0;
    end
    always @(negedge i_clk) begin
        if (hold_cnt > 0) begin
            hold_cnt--;
            rsp_if.ready <= 1'b0;
        end else if (hold_req) begin
            hold_cnt = 400;
            rsp_if.ready <= 1'b0;
        end else if (rsp_taken) begin
            rcv_gap = $urandom_range(0, 6);
            rsp_if.ready <= (rcv_gap == 0);
        end else if (rcv_gap > 0) begin
            rcv_gap--;
            rsp_if.ready <= (rcv_gap == 0);
        end else begin
            rsp_if.ready <= 1'b1;
        end
    end

    // Monitor: predict on accepted requests, check accepted results.
    always @(posedge i_clk) begin
        stq_pkg::t_rsp exp_r;
        if (i_rst_n) begin
            if (req_if.valid && req_if.ready) predict_request(req_if.data);
            if (rsp_if.valid && rsp_if.ready) begin
                if (expected_rsps.size() == 0) begin
                    $display("%0t: unexpected result, expected none, actual %p",
                             $time, rsp_if.data);
                    errors++;
                end else begin
                    exp_r = expected_rsps.pop_front();
                    if (rsp_if.data !== exp_r) begin
                        $display("%0t: mismatch, expected %p, actual %p",
                                 $time, exp_r, rsp_if.data);
                        errors++;
                    end
                end
            end
        end
    end

    function automatic stq_pkg::t_req random_req();
        int r;
        int d;
        r = $urandom_range(0, 99);
        if (r < 40) return mk_req(stq_pkg::REQ_TICK, $urandom, $urandom, $urandom);
        if (r < 72) begin
            d = $urandom_range(0, 9) == 0 ? $urandom : $urandom_range(0, 12);
            return mk_req(stq_pkg::REQ_ADD, d, $urandom, $urandom);
        end
        if (r < 86) return mk_req(stq_pkg::REQ_REMOVE, $urandom, $urandom, $urandom);
        return mk_req(stq_pkg::REQ_QUERY, $urandom, $urandom, $urandom);
    endfunction

    task automatic wait_drained();
        while (pending_reqs.size() > 0 || req_if.valid || expected_rsps.size() > 0)
            @(posedge i_clk);
    endtask

    int n;
    initial begin
        errors = 0;
        hold_req = 0;
        now_sec = 0;
        order_q = {};
        for (int i = 0; i < DEPTH; i++) busy_slot[i] = 1'b0;
        i_rst_n = 1'b0;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed: empty ops, zero delay, extremes, equal deadlines, full table.
        pending_reqs.push_back(mk_req(stq_pkg::REQ_TICK, 0, 0, 0));
        pending_reqs.push_back(mk_req(stq_pkg::REQ_QUERY, 0, 0, 15));
        pending_reqs.push_back(mk_req(stq_pkg::REQ_REMOVE, 0, 0, 0));
        pending_reqs.push_back(mk_req(stq_pkg::REQ_ADD, 0, 16'hFFFF, 0));
        pending_reqs.push_back(mk_req(stq_pkg::REQ_ADD, 16'hFFFF, 16'hFFFF, 15));
        pending_reqs.push_back(mk_req(stq_pkg::REQ_ADD, 1, 0, 0));
        pending_reqs.push_back(mk_req(stq_pkg::REQ_ADD, 3, 16'h1234, 0));
        pending_reqs.push_back(mk_req(stq_pkg::REQ_ADD, 3, 16'h5678, 0));
        pending_reqs.push_back(mk_req(stq_pkg::REQ_QUERY, 0, 0, 1));
        pending_reqs.push_back(mk_req(stq_pkg::REQ_REMOVE, 0, 0, 3));
        pending_reqs.push_back(mk_req(stq_pkg::REQ_REMOVE, 0, 0, 0));
        for (int i = 0; i < 14; i++)
            pending_reqs.push_back(mk_req(stq_pkg::REQ_ADD, 2 + (i % 3), i, 0));
        wait_drained();
        // Table now full; expiry happens on later ticks.
        pending_reqs.push_back(mk_req(stq_pkg::REQ_ADD, 5, 1, 0));
        pending_reqs.push_back(mk_req(stq_pkg::REQ_TICK, 0, 0, 0));
        pending_reqs.push_back(mk_req(stq_pkg::REQ_TICK, 0, 0, 0));
        pending_reqs.push_back(mk_req(stq_pkg::REQ_TICK, 0, 0, 0));

        // Back up the output so the block stalls its input.
        hold_req = 1;
        for (int i = 0; i < 6; i++) pending_reqs.push_back(random_req());
        wait (hold_cnt > 0);
        hold_req = 0;
        wait (hold_cnt == 0);
        wait_drained();

        n = 0;
        while (n < 355) begin
            pending_reqs.push_back(random_req());
            n++;
            if (n % 120 == 0) wait_drained();
            while (pending_reqs.size() > 4) @(posedge i_clk);
        end
        wait_drained();
        repeat (200) @(posedge i_clk);
        if (errors == 0 && expected_rsps.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end
endmodule

[filelist.f]
+incdir+rtl
rtl/stq_pkg.sv
rtl/stq_chan_if.sv
rtl/stq_store.sv
rtl/sorted_timer_queue.sv
tb/tb_top.sv
